@@ rtl/core/ukv_pkg.sv @@
package ukv_pkg;

  typedef logic [2:0]  op_t;
  typedef logic [31:0] key_t;
  typedef logic [31:0] value_t;
  typedef logic [5:0]  index_t;
  typedef logic [6:0]  count_t;
  typedef logic [6:0]  cap_t;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 80;

  typedef struct packed {
    logic [6:0] pad;
    index_t     index;
    value_t     value;
    key_t       key;
    op_t        op;
  } in_word_t;

  typedef struct packed {
    logic [6:0] pad;
    logic       is_empty;
    count_t     count;
    value_t     value_out;
    key_t       key_out;
    logic       ok;
  } out_word_t;

  localparam op_t OP_INSERT           = 3'd0;
  localparam op_t OP_UPDATE           = 3'd1;
  localparam op_t OP_INSERT_OR_UPDATE = 3'd2;
  localparam op_t OP_ERASE            = 3'd3;
  localparam op_t OP_CONTAINS         = 3'd4;
  localparam op_t OP_GET_BY_KEY       = 3'd5;
  localparam op_t OP_GET_BY_INDEX     = 3'd6;

  localparam logic REG_CAPACITY   = 1'b0;
  localparam cap_t CAPACITY_RESET = 7'd64;

endpackage

@@ rtl/core/unsorted_key_value_table_unit.sv @@
// Key-value table held as a packed, unordered array in two single-port-read RAMs.
// Input stream s_*: one transfer carries op, key, value and index. Output stream
// m_*: one transfer per input with ok, key_out, value_out, count and is_empty.
// The APB port holds the capacity register at byte address 0; pready is tied high.
// A key lookup walks the live entries one per cycle, through all of them when the
// key is missing, stopping at the key on a hit. Erase of a present key searches
// up to it, then moves each later entry down one per cycle. get_by_index reads the
// entry at the index directly, and an unused op code goes straight to the result.
// The RAM read port, shared by search and shift, sets the rate; one operation
// is in flight at a time.
// The result sits in an output register; s_tready is high again as soon as that
// register is loaded, so the next operation may start while the result waits.
// If the receiver stalls, the finished operation waits until the output register
// frees, and no further input is taken meanwhile.
// Reset clears the live count to zero and sets capacity to 64; RAM contents are
// left as they are, as only entries below the count are ever read.
module unsorted_key_value_table_unit #(
  parameter int DEPTH      = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // op[2:0], key[34:3], value[66:35], index[72:67], zero pad
  input  logic [ukv_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // ok[0], key_out[32:1], value_out[64:33], count[71:65], is_empty[72], zero pad
  output logic [ukv_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (CW > 6) ? CW : 6;
  localparam int FW   = (CW > 7) ? CW : 7;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_ACT    = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_IDX    = 3'd4;
  localparam logic [2:0] ST_IDXW   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]            state;
  logic [CW-1:0]         live_count;
  ukv_pkg::cap_t         capacity;

  ukv_pkg::op_t          op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  ukv_pkg::index_t       idx_r;
  logic [CW-1:0]         ptr;
  logic                  pend;
  logic [CW-1:0]         pend_pos;
  logic                  found;
  logic [CW-1:0]         pos;
  logic                  res_ok;
  ukv_pkg::key_t         res_key;
  ukv_pkg::value_t       res_val;

  logic [AW-1:0]         rd_addr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  k_we;
  logic                  v_we;
  logic [AW-1:0]         wr_addr;
  logic [KEY_BITS-1:0]   wk;
  logic [VALUE_BITS-1:0] wv;

  logic                  issue;
  logic                  hit;
  logic                  full;
  logic                  idx_ok;
  logic                  out_free;
  logic [CW-1:0]         shift_dst;
  logic                  cfg_wr;
  ukv_pkg::in_word_t     in_word;
  ukv_pkg::out_word_t    out_word;

  assign in_word   = ukv_pkg::in_word_t'(s_tdata);
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign issue     = ptr < live_count;
  assign hit       = pend && (rd_key == key_r);
  assign full      = (FW'(live_count) >= FW'(capacity)) || (live_count >= CW'(DEPTH));
  assign idx_ok    = IW'(idx_r) < IW'(live_count);
  assign shift_dst = pend_pos - CW'(1);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ukv_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == ukv_pkg::REG_CAPACITY) ? 32'(capacity) : 32'd0;

  always_comb begin
    out_word           = '0;
    out_word.ok        = res_ok;
    out_word.key_out   = res_key;
    out_word.value_out = res_val;
    out_word.count     = ukv_pkg::count_t'(live_count);
    out_word.is_empty  = (live_count == '0);
  end

  always_comb begin
    rd_addr = ptr[AW-1:0];
    if (state == ST_IDX) begin
      rd_addr = AW'(idx_r);
    end
  end

  always_comb begin
    k_we    = 1'b0;
    v_we    = 1'b0;
    wr_addr = live_count[AW-1:0];
    wk      = key_r;
    wv      = val_r;
    if (state == ST_ACT) begin
      case (op_r)
        ukv_pkg::OP_INSERT: begin
          k_we = !found && !full;
          v_we = !found && !full;
        end
        ukv_pkg::OP_UPDATE: begin
          v_we    = found;
          wr_addr = pos[AW-1:0];
        end
        ukv_pkg::OP_INSERT_OR_UPDATE: begin
          if (found) begin
            v_we    = 1'b1;
            wr_addr = pos[AW-1:0];
          end else begin
            k_we = !full;
            v_we = !full;
          end
        end
        default: begin
          k_we = 1'b0;
        end
      endcase
    end else if (state == ST_SHIFT && pend) begin
      k_we    = 1'b1;
      v_we    = 1'b1;
      wr_addr = shift_dst[AW-1:0];
      wk      = rd_key;
      wv      = rd_val;
    end
  end

  ukv_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (wr_addr),
    .wdata (wk),
    .raddr (rd_addr),
    .rdata (rd_key)
  );

  ukv_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (wr_addr),
    .wdata (wv),
    .raddr (rd_addr),
    .rdata (rd_val)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      live_count <= '0;
      capacity   <= ukv_pkg::CAPACITY_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        capacity <= pwdata[6:0];
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (in_word.op == ukv_pkg::OP_GET_BY_INDEX) begin
              state <= ST_IDX;
            end else if (in_word.op == ukv_pkg::OP_INSERT
                         || in_word.op == ukv_pkg::OP_UPDATE
                         || in_word.op == ukv_pkg::OP_INSERT_OR_UPDATE
                         || in_word.op == ukv_pkg::OP_ERASE
                         || in_word.op == ukv_pkg::OP_CONTAINS
                         || in_word.op == ukv_pkg::OP_GET_BY_KEY) begin
              state <= ST_SEARCH;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SEARCH: begin
          if (hit || (!pend && !issue)) begin
            state <= ST_ACT;
          end
        end
        ST_ACT: begin
          state <= (op_r == ukv_pkg::OP_ERASE && found) ? ST_SHIFT : ST_DONE;
          case (op_r)
            ukv_pkg::OP_INSERT: begin
              if (!found && !full) begin
                live_count <= live_count + CW'(1);
              end
            end
            ukv_pkg::OP_INSERT_OR_UPDATE: begin
              if (!found && !full) begin
                live_count <= live_count + CW'(1);
              end
            end
            default: ;
          endcase
        end
        ST_SHIFT: begin
          if (!pend && !issue) begin
            live_count <= live_count - CW'(1);
            state      <= ST_DONE;
          end
        end
        ST_IDX: begin
          state <= idx_ok ? ST_IDXW : ST_DONE;
        end
        ST_IDXW: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_r    <= in_word.op;
        key_r   <= KEY_BITS'(in_word.key);
        val_r   <= VALUE_BITS'(in_word.value);
        idx_r   <= in_word.index;
        ptr     <= '0;
        pend    <= 1'b0;
        found   <= 1'b0;
        res_ok  <= 1'b0;
        res_key <= '0;
        res_val <= '0;
      end
      ST_SEARCH: begin
        ptr      <= ptr + CW'(issue);
        pend     <= issue;
        pend_pos <= ptr;
        if (hit) begin
          found <= 1'b1;
          pos   <= pend_pos;
          if (op_r == ukv_pkg::OP_GET_BY_KEY) begin
            res_val <= ukv_pkg::value_t'(rd_val);
          end
        end
      end
      ST_ACT: begin
        ptr  <= pos + CW'(1);
        pend <= 1'b0;
        case (op_r)
          ukv_pkg::OP_INSERT:           res_ok <= !found && !full;
          ukv_pkg::OP_INSERT_OR_UPDATE: res_ok <= found || !full;
          ukv_pkg::OP_UPDATE:           res_ok <= found;
          ukv_pkg::OP_CONTAINS:         res_ok <= found;
          ukv_pkg::OP_GET_BY_KEY:       res_ok <= found;
          default:                      res_ok <= 1'b0;
        endcase
      end
      ST_SHIFT: begin
        ptr      <= ptr + CW'(issue);
        pend     <= issue;
        pend_pos <= ptr;
        if (!pend && !issue) begin
          res_ok <= 1'b1;
        end
      end
      ST_IDXW: begin
        res_ok  <= 1'b1;
        res_key <= ukv_pkg::key_t'(rd_key);
        res_val <= ukv_pkg::value_t'(rd_val);
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= out_word;
        end
      end
      default: begin
        pend <= 1'b0;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != ST_IDLE))
    else $error("accepted operation did not start");

  a_count_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    (live_count != $past(live_count)) |->
      ((live_count == $past(live_count) + CW'(1)) || (live_count == $past(live_count) - CW'(1))))
    else $error("live count moved by more than one");

  a_grow_within_depth: assert property (@(posedge clk) disable iff (rst)
    (live_count > $past(live_count)) |-> ($past(live_count) < CW'(DEPTH)))
    else $error("table grew beyond its depth");

  a_shift_never_below_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && pend) |-> (pend_pos != '0))
    else $error("erase shift wrote below the first entry");

  a_done_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> (state == ST_DONE))
    else $error("result dropped while output register busy");

endmodule

@@ rtl/core/ukv_ram.sv @@
module ukv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
